// File: rtl/core/sss_pkg.sv
// Shared types, command codes and font tables for the seven-segment scan display.
`timescale 1ns / 1ps
`default_nettype none
package sss_pkg;

    localparam int NUM_POSITIONS_DEF = 5;
    localparam int BLINK_PERIOD_DEF  = 250;

    localparam int CHAR_W   = 8;
    localparam int POS_W    = 3;
    localparam int OP_W     = 3;
    localparam int SEG_W    = 8;
    localparam int DSEL_W   = 5;
    localparam int BRIGHT_W = 5;
    localparam int CNT_W    = 8;

    localparam logic [BRIGHT_W-1:0] BRIGHT_OFF   = 5'd16;
    localparam logic [7:0]          COLON_RESET  = 8'h01;
    localparam logic [SEG_W-1:0]    MINUS_GLYPH  = 8'h40;
    localparam logic [7:0]          PWM_ENABLE   = 8'hd0;

    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 3'd0,
        OP_PUT_CHAR   = 3'd1,
        OP_SET_ICON   = 3'd2,
        OP_FLASH_ICON = 3'd3,
        OP_FLASH_DIG  = 3'd4,
        OP_CLEAR      = 3'd5
    } t_op;

    typedef enum logic {
        CFG_BRIGHTNESS = 1'b0,
        CFG_COLON_MASK = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic             hit;
        logic             colon;
        logic [SEG_W-1:0] pattern;
    } t_glyph;

    typedef struct packed {
        logic [DSEL_W-1:0] digit_select;
        logic [SEG_W-1:0]  segment;
    } t_scan;

    localparam logic [SEG_W-1:0] FONT_DIGIT [10] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
    };

    localparam logic [SEG_W-1:0] FONT_UPPER [26] = '{
        8'h77, 8'h40, 8'h39, 8'h3f, 8'h79, 8'h71, 8'h40, 8'h76, 8'h06, 8'h40,
        8'h40, 8'h38, 8'h40, 8'h37, 8'h3f, 8'h73, 8'h40, 8'h50, 8'h6d, 8'h40,
        8'h3e, 8'h3e, 8'h40, 8'h76, 8'h40, 8'h40
    };

    localparam logic [SEG_W-1:0] FONT_LOWER [26] = '{
        8'h77, 8'h7c, 8'h58, 8'h5e, 8'h79, 8'h71, 8'h40, 8'h40, 8'h40, 8'h40,
        8'h40, 8'h38, 8'h40, 8'h54, 8'h5c, 8'h73, 8'h67, 8'h50, 8'h40, 8'h40,
        8'h3e, 8'h3e, 8'h40, 8'h40, 8'h40, 8'h40
    };

endpackage
`default_nettype wire

// File: rtl/core/sss_font.sv
// Character decoder: ASCII code to segment glyph through the font tables.
`timescale 1ns / 1ps
`default_nettype none
module sss_font
    import sss_pkg::*;
(
    input  wire logic [CHAR_W-1:0] i_char,
    output t_glyph                 o_glyph
);

    logic [CHAR_W-1:0] ofs_digit;
    logic [CHAR_W-1:0] ofs_upper;
    logic [CHAR_W-1:0] ofs_lower;

    assign ofs_digit = i_char - 8'h30;
    assign ofs_upper = i_char - 8'h41;
    assign ofs_lower = i_char - 8'h61;

    always_comb begin
        o_glyph = '0;
        priority if (i_char >= 8'h30 && i_char <= 8'h39) begin
            o_glyph.hit     = 1'b1;
            o_glyph.pattern = FONT_DIGIT[ofs_digit[3:0]];
        end else if (i_char >= 8'h61 && i_char <= 8'h7a) begin
            o_glyph.hit     = 1'b1;
            o_glyph.pattern = FONT_LOWER[ofs_lower[4:0]];
        end else if (i_char >= 8'h41 && i_char <= 8'h5a) begin
            o_glyph.hit     = 1'b1;
            o_glyph.pattern = FONT_UPPER[ofs_upper[4:0]];
        end else if (i_char == 8'h3a) begin
            o_glyph.colon   = 1'b1;
        end else if (i_char == 8'h2d) begin
            o_glyph.hit     = 1'b1;
            o_glyph.pattern = MINUS_GLYPH;
        end else begin
            o_glyph = '0;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/sss_display_state.sv
// Segment buffer, flash mask, blink timer and scan pointer with command execution.
`timescale 1ns / 1ps
`default_nettype none
module sss_display_state
    import sss_pkg::*;
#(
    parameter int NUM_POSITIONS = NUM_POSITIONS_DEF,
    parameter int BLINK_PERIOD  = BLINK_PERIOD_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [CHAR_W-1:0] i_char,
    input  wire logic [POS_W-1:0]  i_pos,
    input  wire logic [SEG_W-1:0]  i_icons,
    input  wire logic [7:0]        i_colon_mask,
    output logic                   o_tick,
    output t_scan                  o_scan
);

    localparam int STATUS_IDX = NUM_POSITIONS - 1;
    localparam int IDX_W      = (NUM_POSITIONS > 1) ? $clog2(NUM_POSITIONS) : 1;

    logic [SEG_W-1:0] r_buf  [NUM_POSITIONS];
    logic [SEG_W-1:0] r_mask [NUM_POSITIONS];
    logic [SEG_W-1:0] n_buf  [NUM_POSITIONS];
    logic [SEG_W-1:0] n_mask [NUM_POSITIONS];
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_phase, n_phase;

    logic [CNT_W:0]   cnt_inc;
    logic             cnt_wrap;
    logic             tick_phase;
    logic [IDX_W-1:0] idx_eff;
    t_glyph           glyph;

    sss_font u_font (
        .i_char  (i_char),
        .o_glyph (glyph)
    );

    assign cnt_inc    = {1'b0, r_cnt} + 9'd1;
    assign cnt_wrap   = (cnt_inc >= 9'(BLINK_PERIOD));
    assign tick_phase = cnt_wrap ? ~r_phase : r_phase;
    assign idx_eff    = (int'(r_idx) >= NUM_POSITIONS) ? '0 : r_idx;

    always_comb begin
        o_scan.segment = r_buf[idx_eff] ^ (tick_phase ? r_mask[idx_eff] : '0);
        for (int j = 0; j < DSEL_W; j++) begin
            o_scan.digit_select[j] = (int'(idx_eff) == j);
        end
    end

    assign o_tick = i_valid && (i_op == OP_TICK);

    always_comb begin
        n_buf   = r_buf;
        n_mask  = r_mask;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_phase = r_phase;
        if (i_valid) begin
            unique case (i_op)
                OP_TICK: begin
                    n_cnt   = cnt_wrap ? '0 : cnt_inc[CNT_W-1:0];
                    n_phase = tick_phase;
                    n_idx   = (int'(idx_eff) == STATUS_IDX) ? '0 : idx_eff + 1'b1;
                end
                OP_PUT_CHAR: begin
                    for (int i = 0; i < NUM_POSITIONS; i++) begin
                        if (glyph.hit && int'(i_pos) == i) begin
                            n_buf[i] = glyph.pattern;
                        end
                    end
                    if (glyph.colon) begin
                        n_buf[STATUS_IDX] = r_buf[STATUS_IDX] | i_colon_mask;
                    end
                end
                OP_SET_ICON: begin
                    n_buf[STATUS_IDX] = r_buf[STATUS_IDX] | i_icons;
                end
                OP_FLASH_ICON: begin
                    n_mask[STATUS_IDX] = r_mask[STATUS_IDX] | i_icons;
                end
                OP_FLASH_DIG: begin
                    for (int i = 0; i < STATUS_IDX; i++) begin
                        if (int'(i_pos) == i) begin
                            n_mask[i] = '1;
                        end
                    end
                end
                OP_CLEAR: begin
                    for (int i = 0; i < NUM_POSITIONS; i++) begin
                        n_buf[i]  = '0;
                        n_mask[i] = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_POSITIONS; i++) begin
                r_buf[i]  <= '0;
                r_mask[i] <= '0;
            end
            r_idx   <= '0;
            r_cnt   <= '0;
            r_phase <= 1'b0;
        end else begin
            r_buf   <= n_buf;
            r_mask  <= n_mask;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_phase <= n_phase;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/seven_segment_scan_display_core.sv
// Top level of the multiplexed seven-segment scan display controller.
// A scan tick transaction gives its result in the output register in the cycle after it is accepted.
// Throughput: one command or tick per cycle; other commands produce no result.
// The output register frees on the same edge it is taken, so input stalls only on output stall.
// Reset (synchronous, active low) clears buffers, flash mask, blink timer and scan pointer,
// sets brightness to 16 (PWM off) and the colon mask to 1.
`timescale 1ns / 1ps
`default_nettype none
module seven_segment_scan_display_core
    import sss_pkg::*;
#(
    parameter int NUM_POSITIONS = NUM_POSITIONS_DEF,
    parameter int BLINK_PERIOD  = BLINK_PERIOD_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // operation, char_code, position, icon_bits, pad
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // digit_select, segment_pattern, pwm_control, pad
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    logic                r_out_valid;
    logic [23:0]         r_out_data;
    logic [BRIGHT_W-1:0] r_bright;
    logic [7:0]          r_colon;
    logic                accept;
    logic                tick;
    t_scan               scan;
    logic [7:0]          pwm;

    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign accept      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    sss_display_state #(
        .NUM_POSITIONS (NUM_POSITIONS),
        .BLINK_PERIOD  (BLINK_PERIOD)
    ) u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (accept),
        .i_op         (i_s_tdata[2:0]),
        .i_char       (i_s_tdata[10:3]),
        .i_pos        (i_s_tdata[13:11]),
        .i_icons      (i_s_tdata[21:14]),
        .i_colon_mask (r_colon),
        .o_tick       (tick),
        .o_scan       (scan)
    );

    assign pwm = (r_bright >= BRIGHT_OFF) ? 8'h00 : (PWM_ENABLE | {4'h0, r_bright[3:0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright <= BRIGHT_OFF;
            r_colon  <= COLON_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_BRIGHTNESS: begin
                    if (i_cfg_data[4:0] <= BRIGHT_OFF) begin
                        r_bright <= i_cfg_data[4:0];
                    end
                end
                CFG_COLON_MASK: r_colon <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tick) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick) begin
            r_out_data <= {3'b000, pwm, scan.segment, scan.digit_select};
        end
    end

endmodule
`default_nettype wire
